[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only while reset is low.
`define AST_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, also checked through reset.
`define AST_NEXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[hdl/vnf_pkg.sv]
`default_nettype none

package vnf_pkg;

  // 1/(2*pi) in Q0.64, split in halves
  localparam logic [31:0] K_HI   = 32'h28BE60DB;
  localparam logic [31:0] K_LO   = 32'h9391054A;
  // 43758.5453 in Q16.16
  localparam logic [31:0] HASH_M = 32'd2867760025;
  localparam logic [30:0] Q30_ONE = 31'h40000000;

  localparam int HORNER_STEPS = 5;
  localparam logic signed [33:0] HORNER_C [0:HORNER_STEPS] = '{
    -34'sd3864, 34'sd172272, -34'sd5026995, 34'sd85569306,
    -34'sd693598668, 34'sd1686629713
  };

  // register stages from corner index to hash, and from coordinates to octave noise
  localparam int HASH_LAT = 8 + 2 * HORNER_STEPS;
  localparam int OCT_LAT  = 3 + HASH_LAT + 4;

  // divide a Q30 product by 2^30, truncating toward zero
  function automatic logic signed [35:0] q30_trunc(input logic signed [65:0] p);
    logic signed [65:0] b;
    b = p + (p[65] ? 66'sd1073741823 : 66'sd0);
    return b[65:30] >>> 0;
  endfunction

endpackage

`default_nettype wire

[hdl/value_noise_fbm.sv]
// Each start transfer yields a done strobe. Throughput: one sample per cycle outside reset;
// every octave and corner hash has its own pipelined lane.
// busy is high only while rst is high; results cannot be held off by the receiver.
// Reset (synchronous, rst high) clears the valid pipeline only; in-flight samples are dropped.
`default_nettype none

module value_noise_fbm
  import vnf_pkg::*;
#(
  parameter int OCTAVES   = 5,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_coord,
  output logic             done,
  output logic      [16:0] noise_value
);

  localparam int LAT = OCT_LAT + 1;

  logic [15:0] nv [0:OCTAVES-1];
  logic [LAT-1:0] vld;
  logic [19:0] sum;

  assign busy = rst;
  assign done = vld[LAT-1];

  for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
    vnf_octave #(.FRAC_BITS(FRAC_BITS)) u_oct (
      .clk (clk),
      .x   (x_coord << i),
      .y   (y_coord << i),
      .nv  (nv[i])
    );
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      sum = sum + 20'(nv[i] >> i);
    end
  end

  always_ff @(posedge clk) begin
    noise_value <= sum[16:0];
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

endmodule

`default_nettype wire

[hdl/vnf_hash.sv]
`default_nettype none

module vnf_hash
  import vnf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] n,
  output logic      [15:0] hash
);

  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] t;
    logic [30:0] t2;
  } side_t;

  localparam int SD = 2 * HORNER_STEPS;

  logic [63:0] plo;
  logic [63:0] phi;
  logic        neg;
  logic [31:0] phase;
  logic [1:0]  quad3;
  logic [30:0] t3;
  logic [61:0] tt;
  side_t       sd [0:SD];
  logic signed [65:0] prod [1:HORNER_STEPS];
  logic signed [33:0] acc  [1:HORNER_STEPS];
  logic signed [65:0] ps;
  logic [1:0]  quad_s;
  logic signed [35:0] s_tr;
  logic [30:0] s;
  logic        sgn_s;
  logic [62:0] mag;
  logic        sgn_m;
  logic [45:0] m46;

  assign tt  = t3 * t3;
  assign s_tr = q30_trunc(ps);
  assign m46 = sgn_m ? (~mag[45:0] + 46'd1) : mag[45:0];

  always_ff @(posedge clk) begin
    plo   <= n * K_LO;
    phi   <= n * K_HI;
    neg   <= n[31];
    phase <= plo[63:32] + phi[31:0] - (neg ? K_LO : 32'd0);
    quad3 <= phase[31:30];
    t3    <= phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    sd[0] <= '{quad: quad3, t: t3, t2: tt[60:30]};
    for (int j = 1; j <= SD; j++) begin
      sd[j] <= sd[j-1];
    end
  end

  for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        prod[k] <= HORNER_C[0] * $signed({1'b0, sd[0].t2});
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        prod[k] <= acc[k-1] * $signed({1'b0, sd[2*k-2].t2});
      end
    end
    always_ff @(posedge clk) begin
      acc[k] <= 34'(36'(HORNER_C[k]) + q30_trunc(prod[k]));
    end
  end

  always_ff @(posedge clk) begin
    ps     <= acc[HORNER_STEPS] * $signed({1'b0, sd[SD].t});
    quad_s <= sd[SD].quad;
    // clamp to [0, 1.0]
    if (s_tr[35]) begin
      s <= '0;
    end else if (s_tr > $signed({5'b0, Q30_ONE})) begin
      s <= Q30_ONE;
    end else begin
      s <= s_tr[30:0];
    end
    sgn_s <= quad_s[1];
    mag   <= s * HASH_M;
    sgn_m <= sgn_s;
    hash  <= m46[45:30];
  end

endmodule

`default_nettype wire

[hdl/vnf_octave.sv]
`default_nettype none

module vnf_octave
  import vnf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  output logic      [15:0] nv
);

  logic [31:0] cx, cy;
  logic [15:0] fx_c, fy_c, fx, fy;
  logic [31:0] n;
  logic [15:0] f2x, f2y;
  logic [17:0] tx, ty;
  logic [33:0] pux, puy;
  logic [31:0] n0, n1, n2, n3;
  logic [16:0] u_d [0:HASH_LAT];
  logic [16:0] v_d [0:HASH_LAT];
  logic [15:0] ha, hb, hc, hd;
  logic [31:0] sqx, sqy;
  logic signed [16:0] dba, ddc;
  logic signed [35:0] top_c, bot_c;
  logic signed [35:0] top1, bot1, top2;
  logic signed [36:0] diff;
  logic [16:0] v1, v2;
  logic signed [55:0] r;

  if (FRAC_BITS >= 16) begin : g_fr_hi
    assign fx_c = x[FRAC_BITS-1 -: 16];
    assign fy_c = y[FRAC_BITS-1 -: 16];
  end else begin : g_fr_lo
    assign fx_c = {x[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    assign fy_c = {y[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
  end

  assign sqx = fx * fx;
  assign sqy = fy * fy;
  assign pux = f2x * tx;
  assign puy = f2y * ty;

  always_ff @(posedge clk) begin
    cx <= 32'($signed(x) >>> FRAC_BITS);
    cy <= 32'($signed(y) >>> FRAC_BITS);
    fx <= fx_c;
    fy <= fy_c;
    n   <= cx + cy * 32'd157;
    f2x <= sqx[31:16];
    f2y <= sqy[31:16];
    tx  <= 18'd196608 - {1'b0, fx, 1'b0};
    ty  <= 18'd196608 - {1'b0, fy, 1'b0};
    n0 <= n;
    n1 <= n + 32'd1;
    n2 <= n + 32'd157;
    n3 <= n + 32'd158;
    u_d[0] <= pux[32:16];
    v_d[0] <= puy[32:16];
    for (int j = 1; j <= HASH_LAT; j++) begin
      u_d[j] <= u_d[j-1];
      v_d[j] <= v_d[j-1];
    end
  end

  vnf_hash u_ha (.clk(clk), .n(n0), .hash(ha));
  vnf_hash u_hb (.clk(clk), .n(n1), .hash(hb));
  vnf_hash u_hc (.clk(clk), .n(n2), .hash(hc));
  vnf_hash u_hd (.clk(clk), .n(n3), .hash(hd));

  always_comb begin
    dba   = $signed({1'b0, hb}) - $signed({1'b0, ha});
    ddc   = $signed({1'b0, hd}) - $signed({1'b0, hc});
    top_c = $signed({4'b0, ha, 16'b0}) + dba * $signed({1'b0, u_d[HASH_LAT]});
    bot_c = $signed({4'b0, hc, 16'b0}) + ddc * $signed({1'b0, u_d[HASH_LAT]});
  end

  always_ff @(posedge clk) begin
    top1 <= top_c;
    bot1 <= bot_c;
    v1   <= v_d[HASH_LAT];
    diff <= bot1 - top1;
    top2 <= top1;
    v2   <= v1;
    r    <= $signed({top2, 16'b0}) + diff * $signed({1'b0, v2});
    // drop negative blends to zero
    nv   <= r[55] ? 16'd0 : r[47:32];
  end

endmodule

`default_nettype wire

[hdl/value_noise_fbm_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module value_noise_fbm_checker #(
  parameter int LATENCY = 26
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [16:0] noise_value
);

  `AST_IMPLY(a_done_from_transfer, clk, rst, done, $past(start && !busy, LATENCY))
  `AST_IMPLY(a_sum_bound, clk, rst, done, noise_value <= 17'd130560)
  `AST_NEXT(a_reset_quiet, clk, rst, !done)

endmodule

bind value_noise_fbm value_noise_fbm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .noise_value (noise_value)
);

`default_nettype wire

[tb/vnf_checker.sv]
`default_nettype none

module vnf_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_coord,
  input  wire logic        done,
  input  wire logic [16:0] noise_value,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_OCT = 5;
  localparam int FRAC_W = 16;
  localparam logic [63:0] TURN_K = 64'h28BE60DB9391054A;
  localparam longint unsigned SIN_SCALE = 64'd2867760025;
  localparam longint ONE_Q30 = 64'sd1073741824;

  logic [16:0] noise_q[$];

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) / ONE_Q30;
  endfunction

  function automatic longint sine_q30(logic [31:0] n);
    logic [63:0] phase_prod;
    logic [31:0] phase;
    longint t, t2, acc, s;
    phase_prod = {{32{n[31]}}, n} * TURN_K;
    phase = phase_prod[63:32];
    t = longint'(phase[29:0]);
    if (phase[30]) t = ONE_Q30 - t;
    t2 = mul_q30(t, t);
    acc = -3864;
    acc = 172272 + mul_q30(acc, t2);
    acc = -5026995 + mul_q30(acc, t2);
    acc = 85569306 + mul_q30(acc, t2);
    acc = -693598668 + mul_q30(acc, t2);
    acc = 1686629713 + mul_q30(acc, t2);
    s = mul_q30(acc, t);
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    return phase[31] ? -s : s;
  endfunction

  function automatic longint lattice_hash(logic [31:0] n);
    longint s;
    logic [63:0] mag, prod;
    s = sine_q30(n);
    mag = 64'(s < 0 ? -s : s) * SIN_SCALE;
    prod = (s < 0) ? (64'd0 - mag) : mag;
    return longint'(prod[45:30]);
  endfunction

  function automatic longint fade(logic [15:0] f);
    longint f2;
    f2 = (longint'(f) * longint'(f)) >>> 16;
    return (f2 * (196608 - 2 * longint'(f))) >>> 16;
  endfunction

  function automatic logic [15:0] octave_value(logic [31:0] x, logic [31:0] y);
    logic [31:0] cx, cy, n;
    longint u, v, a, b, c, d, top, bot, r;
    cx = 32'($signed(x) >>> FRAC_W);
    cy = 32'($signed(y) >>> FRAC_W);
    u = fade(x[15:0]);
    v = fade(y[15:0]);
    n = cx + cy * 32'd157;
    a = lattice_hash(n);
    b = lattice_hash(n + 32'd1);
    c = lattice_hash(n + 32'd157);
    d = lattice_hash(n + 32'd158);
    top = a * 65536 + (b - a) * u;
    bot = c * 65536 + (d - c) * u;
    r = top * 65536 + (bot - top) * v;
    if (r < 0) r = 0;
    return r[47:32];
  endfunction

  function automatic logic [16:0] fbm_value(logic [31:0] x, logic [31:0] y);
    logic [31:0] sum;
    sum = 0;
    for (int i = 0; i < NUM_OCT; i++)
      sum += 32'(octave_value(x << i, y << i)) >> i;
    return sum[16:0];
  endfunction

  assign pending = noise_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) noise_q = {noise_q, fbm_value(x_coord, y_coord)};
      if (done) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected noise_value expected none actual %0d",
                   $time, noise_value);
          fail_count++;
        end else begin
          logic [16:0] want;
          want = noise_q.pop_front();
          if (want !== noise_value) begin
            $display("%0t: noise_value expected %0d actual %0d", $time, want, noise_value);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_value_noise_fbm.sv]
`default_nettype none

module tb_value_noise_fbm;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_SAMPLES = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] x_coord = '0;
  logic [31:0] y_coord = '0;
  logic        busy, done;
  logic [16:0] noise_value;
  int          fail_count, pending;
  int          cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  value_noise_fbm dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_coord(x_coord), .y_coord(y_coord), .done(done), .noise_value(noise_value)
  );

  vnf_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .x_coord(x_coord),
    .y_coord(y_coord), .done(done), .noise_value(noise_value),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // hold start and the point until the transfer; the caller drops start
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    start <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] rand_coord();
    unique case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
    endcase
  endfunction

  logic [31:0] edge_vals [0:7] = '{32'h00000000, 32'h0000FFFF, 32'h00010000, 32'h7FFFFFFF,
                                   32'h80000000, 32'hFFFFFFFF, 32'h0000_8000, 32'hFFFF0001};

  initial begin
    int gap;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[7 - i]);
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[i]);
    send_point(32'h55555555, 32'hAAAAAAAA);
    send_point(32'hAAAAAAAA, 32'h55555555);
    start <= 1'b0;
    // let the pipeline empty before random traffic
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < RAND_SAMPLES; i++) begin
      send_point(rand_coord(), rand_coord());
      if ($urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
